// File: sv/spkr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_pkg
// Shared types and constants for the speaker gate to pcm sample block.
// ----------------------------------------------------------------------------
package spkr_pkg;

    localparam int unsigned RING_DEPTH_DEF = 1024;

    localparam logic [15:0] GATE_PORT  = 16'h0061;
    localparam logic [7:0]  LEVEL_HIGH = 8'hFF;
    localparam logic [7:0]  LEVEL_LOW  = 8'h00;

    localparam int unsigned CPU_HZ  = 4770000;
    localparam int unsigned TICK_HZ = 11000;
    localparam logic [15:0] CPS_RESET = 16'(CPU_HZ / TICK_HZ);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic wr_port;
        logic rd_port;
        logic tick_stop;
        logic tick_start;
        logic pop;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ring_empty;
        logic stamp_below;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: sv/spkr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_in_if
// Input channel: port accesses and sample ticks.
// ----------------------------------------------------------------------------
interface spkr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
    logic [31:0] cycle_stamp;

    modport source (output valid, opcode, port_addr, write_data, cycle_stamp,
                    input ready);
    modport sink (input valid, opcode, port_addr, write_data, cycle_stamp,
                  output ready);
endinterface
`default_nettype wire

// File: sv/spkr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_out_if
// Output channel: port read responses and audio samples.
// ----------------------------------------------------------------------------
interface spkr_out_if;
    logic       valid;
    logic       ready;
    logic       is_sample;
    logic [7:0] read_data;
    logic [7:0] sample_level;
    logic       playing;
    logic       overflow_seen;

    modport source (output valid, is_sample, read_data, sample_level, playing,
                    overflow_seen, input ready);
    modport sink (input valid, is_sample, read_data, sample_level, playing,
                  overflow_seen, output ready);
endinterface
`default_nettype wire

// File: sv/spkr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module spkr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/spkr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_ctrl
// Controller: decodes accepted transactions and sequences the tick pop loop.
// ----------------------------------------------------------------------------
module spkr_ctrl
    import spkr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_sts       i_sts,
    output logic            o_ready,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept  = o_ready && i_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_opcode))
                        OP_WRITE: o_cmd.wr_port = 1'b1;
                        OP_READ:  o_cmd.rd_port = 1'b1;
                        OP_TICK: begin
                            if (i_sts.ring_empty) begin
                                o_cmd.tick_stop = 1'b1;
                            end else begin
                                o_cmd.tick_start = 1'b1;
                                n_state          = ST_POP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                if (!i_sts.ring_empty && i_sts.stamp_below) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: sv/spkr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spkr_dp
// Datapath: gate latch, stamp ring, play clock, level and output register.
// ----------------------------------------------------------------------------
module spkr_dp
    import spkr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic [15:0] i_port_addr,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [31:0] i_cycle_stamp,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    spkr_out_if.source       o_result
);

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);

    logic [15:0]      r_cps;
    logic [7:0]       r_latch;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [31:0]      r_play_clock;
    logic             r_play_en;
    logic             r_level;
    logic             r_ovf;

    logic             r_out_valid;
    logic             r_out_is_sample;
    logic [7:0]       r_out_read_data;
    logic [7:0]       r_out_level;
    logic             r_out_playing;
    logic             r_out_ovf;

    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] rd_addr;
    logic [31:0]      rd_data;
    logic             gate_hit;
    logic             toggle;
    logic             ring_full;
    logic             push;
    logic             out_free;

    assign head_next = (r_head == PTR_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == PTR_W'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign rd_addr   = i_cmd.pop ? tail_next : r_tail;

    assign gate_hit  = (i_port_addr == GATE_PORT);
    assign toggle    = gate_hit && ((i_write_data[1] ^ r_latch[1]) == 1'b1);
    assign ring_full = (head_next == r_tail);
    assign push      = i_cmd.wr_port && toggle && !ring_full;

    assign out_free  = !r_out_valid || o_result.ready;

    assign o_sts.ring_empty  = (r_head == r_tail);
    assign o_sts.stamp_below = (rd_data < r_play_clock);
    assign o_sts.out_free    = out_free;

    spkr_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_head),
        .i_wdata (i_cycle_stamp),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ring and playback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps        <= CPS_RESET;
            r_latch      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_play_clock <= '0;
            r_play_en    <= 1'b0;
            r_level      <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cps <= i_cfg_wdata;
            end
            if (i_cmd.wr_port && gate_hit) begin
                r_latch <= i_write_data;
                if (toggle) begin
                    if (ring_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_head <= head_next;
                    end
                    if (!r_play_en) begin
                        r_play_clock <= i_cycle_stamp;
                        r_play_en    <= 1'b1;
                    end
                end
            end
            if (i_cmd.tick_stop) begin
                r_play_en <= 1'b0;
            end
            if (i_cmd.tick_start) begin
                r_play_clock <= r_play_clock + 32'(r_cps);
            end
            if (i_cmd.pop) begin
                r_tail  <= tail_next;
                r_level <= !r_level;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_port || i_cmd.tick_stop || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_port) begin
            r_out_is_sample <= 1'b0;
            r_out_read_data <= gate_hit ? r_latch : 8'h00;
            r_out_level     <= LEVEL_LOW;
            r_out_playing   <= 1'b0;
            r_out_ovf       <= r_ovf;
        end else if (i_cmd.tick_stop) begin
            r_out_is_sample <= 1'b1;
            r_out_read_data <= 8'h00;
            r_out_level     <= LEVEL_LOW;
            r_out_playing   <= 1'b0;
            r_out_ovf       <= r_ovf;
        end else if (i_cmd.emit) begin
            r_out_is_sample <= 1'b1;
            r_out_read_data <= 8'h00;
            r_out_level     <= r_level ? LEVEL_HIGH : LEVEL_LOW;
            r_out_playing   <= 1'b1;
            r_out_ovf       <= r_ovf;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.is_sample     = r_out_is_sample;
    assign o_result.read_data     = r_out_read_data;
    assign o_result.sample_level  = r_out_level;
    assign o_result.playing       = r_out_playing;
    assign o_result.overflow_seen = r_out_ovf;

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_ovf)) |-> r_ovf)
        else $error("overflow flag cleared");

    // never pop an empty ring
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_head != r_tail))
        else $error("pop on empty ring");

    // stopped playback means nothing queued
    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_play_en |-> (r_head == r_tail))
        else $error("ring holds stamps while stopped");

    // results only load into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_port || i_cmd.tick_stop || i_cmd.emit) |-> out_free)
        else $error("result overwrote pending transaction");

endmodule
`default_nettype wire

// File: sv/speaker_toggle_to_pcm_samples.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speaker_toggle_to_pcm_samples
// Speaker gate port watcher that turns bit 1 toggles into pcm samples.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  i_item     in   valid / ready    opcode, port_addr, write_data, cycle_stamp
//  o_result   out  valid / ready    is_sample, read_data, sample_level,
//                                   playing, overflow_seen
//  i_cfg_*    in   write enable     cycles_per_sample
//
//  port write, port read, tick on empty ring: handled on acceptance in idle
//  tick otherwise: pop state, then emit state; stamps popped one per cycle
//  through the registered read port of the stamp ring
//  reset is synchronous, active low; the ring needs no clearing pass
//  input is held off while the output register is full and not taken
// ----------------------------------------------------------------------------
module speaker_toggle_to_pcm_samples
    import spkr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    spkr_in_if.sink          i_item,
    spkr_out_if.source       o_result
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    assign i_item.ready = ready;

    spkr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_opcode (i_item.opcode),
        .i_sts    (sts),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    spkr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_port_addr   (i_item.port_addr),
        .i_write_data  (i_item.write_data),
        .i_cycle_stamp (i_item.cycle_stamp),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire
